[rtl/core/aifp_pkg.sv]
`default_nettype none

package aifp_pkg;

    localparam int CNT_W = 11;
    localparam logic [CNT_W-1:0] MAX_FIELD_CHARS = 11'd1024;

    // base codes
    localparam logic [2:0] B_AUTO = 3'd0;
    localparam logic [2:0] B_BIN  = 3'd1;
    localparam logic [2:0] B_OCT  = 3'd2;
    localparam logic [2:0] B_DEC  = 3'd3;
    localparam logic [2:0] B_HEX  = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NODIG = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // result sizes
    localparam logic [1:0] SZ_8  = 2'd0;
    localparam logic [1:0] SZ_16 = 2'd1;
    localparam logic [1:0] SZ_32 = 2'd2;
    localparam logic [1:0] SZ_64 = 2'd3;

    // config register indexes
    localparam logic [1:0] R_BASE_MODE   = 2'd0;
    localparam logic [1:0] R_MAX_CHARS   = 2'd1;
    localparam logic [1:0] R_UNSIGNED    = 2'd2;
    localparam logic [1:0] R_RESULT_SIZE = 2'd3;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
    } in_word_t;

    typedef struct packed {
        logic [63:0]      value;
        logic [1:0]       status;
        logic             pushed_back;
        logic [CNT_W-1:0] chars_used;
    } res_word_t;

    typedef struct packed {
        logic [2:0]       base_mode;
        logic [CNT_W-1:0] max_chars;
        logic             unsigned_result;
        logic [1:0]       result_size;
    } cfg_t;

    // classified character
    typedef struct packed {
        logic       is_end;
        logic       is_sign;
        logic       is_minus;
        logic       is_x;
        logic       is_b;
        logic       is_zero;
        logic       digit_ok;
        logic [3:0] digit;
    } cls_t;

    // unshaped result
    typedef struct packed {
        logic [63:0]      acc;
        logic             neg;
        logic [1:0]       status;
        logic             pushed;
        logic [CNT_W-1:0] used;
    } raw_t;

endpackage

`default_nettype wire

[rtl/core/ascii_integer_field_parser_core.sv]
`default_nettype none

// channel   | handshake          | word
// ----------+--------------------+-------------------------------------------
// item      | push / full        | kind, char_code
// result    | empty / pop        | value, status, pushed_back, chars_used
// config    | cfg_wr, cfg_addr   | cfg_data (base_mode, max_chars, unsigned,
//           |                    | result_size), no read-back
//
// One character per cycle unless 2 results wait; a word is classified into a
// 2-deep queue and the parser state takes one word per cycle, so the result for
// a field's end word is written into the result queue behind the result port.
// Reset clears both queues and the field state; config resets to decimal,
// 1024 chars, signed, 32-bit. The parser stalls only when 2 results wait.

module ascii_integer_field_parser_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire aifp_pkg::in_word_t    item,
    output logic                       empty,
    input  wire logic                  pop,
    output aifp_pkg::res_word_t        result,
    input  wire logic                  cfg_wr,
    input  wire logic [1:0]            cfg_addr,
    input  wire logic [aifp_pkg::CNT_W-1:0] cfg_data
);
    import aifp_pkg::*;

    cfg_t cfg_reg;
    logic cls_valid, cls_take;
    cls_t cls_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_mode       <= B_DEC;
            cfg_reg.max_chars       <= MAX_FIELD_CHARS;
            cfg_reg.unsigned_result <= 1'b0;
            cfg_reg.result_size     <= SZ_32;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_addr)
                R_BASE_MODE:   cfg_reg.base_mode       <= cfg_data[2:0];
                R_MAX_CHARS:   cfg_reg.max_chars       <= cfg_data;
                R_UNSIGNED:    cfg_reg.unsigned_result <= cfg_data[0];
                R_RESULT_SIZE: cfg_reg.result_size     <= cfg_data[1:0];
                default:       cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    aifp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cls_valid (cls_valid),
        .cls_head  (cls_head),
        .cls_take  (cls_take)
    );

    aifp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cls_valid (cls_valid),
        .cls_head  (cls_head),
        .cls_take  (cls_take),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire

[rtl/core/aifp_front.sv]
`default_nettype none

module aifp_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire aifp_pkg::in_word_t item,
    output logic                  cls_valid,
    output aifp_pkg::cls_t        cls_head,
    input  wire logic             cls_take
);
    import aifp_pkg::*;

    cls_t       q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg, cnt_next;
    cls_t       cls;
    logic [7:0] ch;
    logic [3:0] hexv;
    logic       wr, rd;

    always_comb
    begin
        ch   = item.char_code;
        cls  = '0;
        hexv = 4'd0;
        if (item.kind)
        begin
            cls.is_end = 1'b1;
        end
        else
        begin
            cls.is_sign  = (ch == 8'h2B) || (ch == 8'h2D);
            cls.is_minus = (ch == 8'h2D);
            cls.is_x     = (ch == 8'h78) || (ch == 8'h58);
            cls.is_b     = (ch == 8'h62) || (ch == 8'h42);
            cls.is_zero  = (ch == 8'h30);
            if (ch >= 8'h30 && ch <= 8'h39)
            begin
                cls.digit_ok = 1'b1;
                hexv         = 4'(ch - 8'h30);
            end
            else if (ch >= 8'h61 && ch <= 8'h66)
            begin
                cls.digit_ok = 1'b1;
                hexv         = 4'(ch - 8'h57);
            end
            else if (ch >= 8'h41 && ch <= 8'h46)
            begin
                cls.digit_ok = 1'b1;
                hexv         = 4'(ch - 8'h37);
            end
            cls.digit = hexv;
        end
    end

    assign full      = (cnt_reg == 2'd2);
    assign wr        = push && !full;
    assign cls_valid = (cnt_reg != 2'd0);
    assign rd        = cls_take && cls_valid;
    assign cls_head  = q_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr && !rd)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (rd && !wr)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr)
            begin
                wp_reg <= ~wp_reg;
            end
            if (rd)
            begin
                rp_reg <= ~rp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            q_reg[wp_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

[rtl/core/aifp_back.sv]
`default_nettype none

module aifp_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire aifp_pkg::cfg_t    cfg,
    input  wire logic              cls_valid,
    input  wire aifp_pkg::cls_t    cls_head,
    output logic                   cls_take,
    output logic                   empty,
    input  wire logic              pop,
    output aifp_pkg::res_word_t    result
);
    import aifp_pkg::*;

    logic [63:0]      acc_reg, acc_next;
    logic             neg_reg, neg_next;
    logic             first_reg, first_next;
    logic [1:0]       pp_reg, pp_next;
    logic [2:0]       ab_reg, ab_next;
    logic [CNT_W-1:0] dc_reg, dc_next;
    logic [CNT_W-1:0] cc_reg, cc_next;

    raw_t             oq_reg [2];
    logic             owp_reg, orp_reg;
    logic [1:0]       ocnt_reg, ocnt_next;

    logic [CNT_W-1:0] limit, cc_inc;
    logic [2:0]       b, eb;
    logic [63:0]      mul;
    logic             dig_in_radix, bad, fin, opop;
    raw_t             fin_raw;
    raw_t             head;
    logic [63:0]      sv;

    always_comb
    begin
        if (cfg.max_chars == '0 || cfg.max_chars > MAX_FIELD_CHARS)
        begin
            limit = MAX_FIELD_CHARS;
        end
        else
        begin
            limit = cfg.max_chars;
        end
    end

    assign cls_take = cls_valid && (ocnt_reg != 2'd2);

    always_comb
    begin
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        first_next   = first_reg;
        pp_next      = pp_reg;
        ab_next      = ab_reg;
        dc_next      = dc_reg;
        cc_next      = cc_reg;
        fin          = 1'b0;
        fin_raw      = '0;
        bad          = 1'b0;
        b            = ab_reg;
        eb           = ab_reg;
        mul          = '0;
        dig_in_radix = 1'b0;
        cc_inc       = cc_reg + CNT_W'(1);
        if (cls_take)
        begin
            if (cls_head.is_end)
            begin
                fin            = 1'b1;
                fin_raw.acc    = acc_reg;
                fin_raw.neg    = neg_reg;
                fin_raw.pushed = 1'b0;
                fin_raw.used   = cc_reg;
                if (cc_reg == '0)
                begin
                    fin_raw.status = ST_EMPTY;
                end
                else
                begin
                    fin_raw.status = (dc_reg != '0) ? ST_OK : ST_NODIG;
                end
            end
            else
            begin
                if (first_reg)
                begin
                    b = (cfg.base_mode > B_HEX) ? B_DEC : cfg.base_mode;
                end
                first_next = 1'b0;
                cc_next    = cc_inc;
                ab_next    = b;
                if (first_reg && cls_head.is_sign)
                begin
                    neg_next = cls_head.is_minus;
                end
                else if (pp_reg == 2'd1 && (b == B_AUTO || b == B_HEX) && cls_head.is_x)
                begin
                    pp_next = 2'd2;
                    ab_next = B_HEX;
                    dc_next = '0;
                end
                else if (pp_reg == 2'd1 && (b == B_AUTO || b == B_BIN) && cls_head.is_b)
                begin
                    pp_next = 2'd2;
                    ab_next = B_BIN;
                    dc_next = '0;
                end
                else if (b == B_AUTO && pp_reg == 2'd0 && cls_head.is_zero)
                begin
                    pp_next = 2'd1;
                    dc_next = dc_reg + CNT_W'(1);
                end
                else
                begin
                    if (b == B_AUTO)
                    begin
                        eb = (pp_reg == 2'd1) ? B_OCT : B_DEC;
                    end
                    else
                    begin
                        eb = b;
                    end
                    ab_next = eb;
                    unique case (eb)
                        B_BIN:
                        begin
                            dig_in_radix = cls_head.digit < 4'd2;
                            mul          = {acc_reg[62:0], 1'b0};
                        end
                        B_OCT:
                        begin
                            dig_in_radix = cls_head.digit < 4'd8;
                            mul          = {acc_reg[60:0], 3'b000};
                        end
                        B_HEX:
                        begin
                            dig_in_radix = 1'b1;
                            mul          = {acc_reg[59:0], 4'b0000};
                        end
                        default:
                        begin
                            dig_in_radix = cls_head.digit < 4'd10;
                            mul          = {acc_reg[60:0], 3'b000} + {acc_reg[62:0], 1'b0};
                        end
                    endcase
                    if (!(cls_head.digit_ok && dig_in_radix))
                    begin
                        bad = 1'b1;
                    end
                    else
                    begin
                        if (dc_reg == '0 && pp_reg == 2'd0 && cls_head.is_zero
                            && (eb == B_HEX || eb == B_BIN))
                        begin
                            pp_next = 2'd1;
                        end
                        else if (pp_reg == 2'd1)
                        begin
                            pp_next = 2'd0;
                        end
                        acc_next = mul + {60'd0, cls_head.digit};
                        dc_next  = dc_reg + CNT_W'(1);
                    end
                end
                if (bad)
                begin
                    fin            = 1'b1;
                    fin_raw.acc    = acc_reg;
                    fin_raw.neg    = neg_reg;
                    fin_raw.pushed = 1'b1;
                    fin_raw.used   = cc_reg;
                    fin_raw.status = (dc_reg != '0) ? ST_OK : ST_NODIG;
                end
                else if (cc_inc >= limit)
                begin
                    fin            = 1'b1;
                    fin_raw.acc    = acc_next;
                    fin_raw.neg    = neg_next;
                    fin_raw.pushed = 1'b0;
                    fin_raw.used   = cc_inc;
                    fin_raw.status = (dc_next != '0) ? ST_OK : ST_NODIG;
                end
            end
            if (fin)
            begin
                acc_next   = '0;
                neg_next   = 1'b0;
                first_next = 1'b1;
                pp_next    = 2'd0;
                dc_next    = '0;
                cc_next    = '0;
            end
        end
    end

    // result queue
    assign empty = (ocnt_reg == 2'd0);
    assign opop  = pop && !empty;
    assign head  = oq_reg[orp_reg];

    always_comb
    begin
        ocnt_next = ocnt_reg;
        if (fin && !opop)
        begin
            ocnt_next = ocnt_reg + 2'd1;
        end
        else if (opop && !fin)
        begin
            ocnt_next = ocnt_reg - 2'd1;
        end
    end

    always_comb
    begin
        sv = head.neg ? (64'd0 - head.acc) : head.acc;
        case (cfg.result_size)
            SZ_8:    sv = {{56{sv[7] & ~cfg.unsigned_result}}, sv[7:0]};
            SZ_16:   sv = {{48{sv[15] & ~cfg.unsigned_result}}, sv[15:0]};
            SZ_32:   sv = {{32{sv[31] & ~cfg.unsigned_result}}, sv[31:0]};
            default: sv = sv;
        endcase
        result.value       = sv;
        result.status      = head.status;
        result.pushed_back = head.pushed;
        result.chars_used  = head.used;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            first_reg <= 1'b1;
            pp_reg    <= 2'd0;
            ab_reg    <= B_DEC;
            dc_reg    <= '0;
            cc_reg    <= '0;
            owp_reg   <= 1'b0;
            orp_reg   <= 1'b0;
            ocnt_reg  <= 2'd0;
        end
        else
        begin
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            first_reg <= first_next;
            pp_reg    <= pp_next;
            ab_reg    <= ab_next;
            dc_reg    <= dc_next;
            cc_reg    <= cc_next;
            ocnt_reg  <= ocnt_next;
            if (fin)
            begin
                owp_reg <= ~owp_reg;
            end
            if (opop)
            begin
                orp_reg <= ~orp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            oq_reg[owp_reg] <= fin_raw;
        end
    end

endmodule

`default_nettype wire
